@@ rtl/core/char_lcd_nibble_byte_sequencer_unit_macros.svh @@
// Assertion macros for the LCD sequencer.
`ifndef CHAR_LCD_NIBBLE_BYTE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_BYTE_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CLNBS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication.
`define CLNBS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define CLNBS_ASSERT_NOW(label, clk, rst, cond, prop, msg)
`define CLNBS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

@@ rtl/core/clnbs_pkg.sv @@
package clnbs_pkg;

  localparam int COLUMNS_DEFAULT     = 16;
  localparam int ROWS_DEFAULT        = 2;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int COL_W = 6;

  // request kinds
  localparam logic [2:0] KIND_PUT       = 3'd0;
  localparam logic [2:0] KIND_CURSOR    = 3'd1;
  localparam logic [2:0] KIND_CLEAR     = 3'd2;
  localparam logic [2:0] KIND_BACKLIGHT = 3'd3;
  localparam logic [2:0] KIND_INIT      = 3'd4;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // port byte bits
  localparam logic [7:0] BIT_RS = 8'h01;
  localparam logic [7:0] BIT_EN = 8'h04;
  localparam logic [7:0] BIT_BL = 8'h08;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;
  localparam logic [6:0] ROW1_OFFSET  = 7'h40;
  localparam logic [3:0] NIB_WAKE     = 4'h3;

  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_200US = 2'd1;
  localparam logic [1:0] WAIT_2MS   = 2'd2;
  localparam logic [1:0] WAIT_5MS   = 2'd3;

  // sequencer counters
  localparam logic [1:0] LAST_PHASE     = 2'd2;
  localparam logic [3:0] VALUE_LAST_NIB = 4'd1;
  localparam logic [3:0] INIT_LAST_NIB  = 4'd13;

  typedef enum logic [1:0] {
    JOB_VALUE,
    JOB_BYTE,
    JOB_INIT
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] value;
    logic       rs;
    logic [1:0] wt;
    logic       bl;
  } job_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [1:0] wt;
  } init_nib_t;

  // init nibbles: three wake-ups, a lone function-set nibble, five commands
  function automatic init_nib_t init_nibble(input logic [3:0] idx);
    init_nib_t r;
    r.wt = WAIT_NONE;
    case (idx)
      4'd0:  begin r.nib = NIB_WAKE; r.wt = WAIT_5MS; end
      4'd1:  begin r.nib = NIB_WAKE; r.wt = WAIT_200US; end
      4'd2:  begin r.nib = NIB_WAKE; r.wt = WAIT_200US; end
      4'd3:  begin r.nib = CMD_FUNC_SET[7:4]; r.wt = WAIT_200US; end
      4'd4:  r.nib = CMD_FUNC_SET[7:4];
      4'd5:  r.nib = CMD_FUNC_SET[3:0];
      4'd6:  r.nib = CMD_DISP_OFF[7:4];
      4'd7:  r.nib = CMD_DISP_OFF[3:0];
      4'd8:  r.nib = CMD_CLEAR[7:4];
      4'd9:  begin r.nib = CMD_CLEAR[3:0]; r.wt = WAIT_2MS; end
      4'd10: r.nib = CMD_ENTRY[7:4];
      4'd11: r.nib = CMD_ENTRY[3:0];
      4'd12: r.nib = CMD_DISP_ON[7:4];
      4'd13: r.nib = CMD_DISP_ON[3:0];
      default: r.nib = 4'h0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/clnbs_front.sv @@
module clnbs_front #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [2:0]        kind,
  input  logic [7:0]        char_code,
  input  logic [7:0]        target_col,
  input  logic [7:0]        target_row,
  input  logic              light_on,
  input  logic              q_full,
  output logic              q_wr,
  output clnbs_pkg::job_t   q_data
);
  import clnbs_pkg::*;

  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic             cursor_row, cursor_row_next;
  logic             backlight_bit, backlight_bit_next;
  logic             accept, known;
  logic [6:0]       addr;

  assign accept = push && !q_full;

  always_comb begin
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    backlight_bit_next = backlight_bit;
    known              = 1'b1;
    q_data.op          = JOB_VALUE;
    q_data.value       = 8'h00;
    q_data.rs          = 1'b0;
    q_data.wt          = WAIT_NONE;
    q_data.bl          = backlight_bit;

    case (kind)
      KIND_PUT: begin
        if (char_code == CHAR_NEWLINE) begin
          cursor_col_next = '0;
          cursor_row_next = (({1'b0, cursor_row} + 2'd1) >= 2'(ROWS)) ? 1'b0 : 1'b1;
        end else if (char_code == CHAR_CR) begin
          cursor_col_next = '0;
        end else begin
          q_data.rs    = 1'b1;
          q_data.value = char_code;
          if (cursor_col < COL_W'(COLUMNS - 1)) cursor_col_next = cursor_col + 1'b1;
        end
      end
      KIND_CURSOR: begin
        cursor_col_next = (target_col >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                      : target_col[COL_W-1:0];
        cursor_row_next = (target_row >= 8'(ROWS)) ? 1'(ROWS - 1) : target_row[0];
      end
      KIND_CLEAR: begin
        q_data.value    = CMD_CLEAR;
        q_data.wt       = WAIT_2MS;
        cursor_col_next = '0;
        cursor_row_next = 1'b0;
      end
      KIND_BACKLIGHT: begin
        backlight_bit_next = light_on;
        q_data.op          = JOB_BYTE;
        q_data.value       = light_on ? BIT_BL : 8'h00;
      end
      KIND_INIT: begin
        q_data.op       = JOB_INIT;
        cursor_col_next = '0;
        cursor_row_next = 1'b0;
      end
      default: known = 1'b0;
    endcase

    // newline, carriage return and set cursor all issue a DDRAM address
    addr = 7'(cursor_col_next) + (cursor_row_next ? ROW1_OFFSET : 7'd0);
    if ((kind == KIND_CURSOR) ||
        ((kind == KIND_PUT) && ((char_code == CHAR_NEWLINE) || (char_code == CHAR_CR)))) begin
      q_data.value = CMD_DDRAM | {1'b0, addr};
    end
  end

  assign q_wr = accept && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col    <= '0;
      cursor_row    <= 1'b0;
      backlight_bit <= 1'b1;
    end else if (accept) begin
      cursor_col    <= cursor_col_next;
      cursor_row    <= cursor_row_next;
      backlight_bit <= backlight_bit_next;
    end
  end

endmodule

@@ rtl/core/clnbs_queue.sv @@
`include "char_lcd_nibble_byte_sequencer_unit_macros.svh"
module clnbs_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  clnbs_pkg::job_t wr_data,
  input  logic            rd,
  output clnbs_pkg::job_t rd_data,
  output logic            full,
  output logic            not_empty
);
  import clnbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  `CLNBS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "queue overfilled")
  `CLNBS_ASSERT_NEXT(a_count_up, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1, "count lost a write")

endmodule

@@ rtl/core/clnbs_back.sv @@
`include "char_lcd_nibble_byte_sequencer_unit_macros.svh"
module clnbs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  clnbs_pkg::job_t q_data,
  output logic            q_rd,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      expander_byte,
  output logic [1:0]      wait_code,
  output logic            last
);
  import clnbs_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] phase;
  logic [3:0] nib;
  logic       out_valid;
  logic       slot_free, emit, load, is_last;
  logic [3:0] nib_val;
  logic [1:0] nib_wt;
  logic [7:0] byte_val;
  logic [1:0] byte_wt;
  init_nib_t  init_entry;

  assign slot_free = !out_valid || pop;
  assign emit      = cur_valid && slot_free;
  assign load      = q_valid && (!cur_valid || (emit && is_last));
  assign q_rd      = load;
  assign empty     = !out_valid;

  always_comb begin
    init_entry = init_nibble(nib);
    nib_val    = 4'h0;
    nib_wt     = WAIT_NONE;
    is_last    = 1'b0;
    case (cur.op)
      JOB_VALUE: begin
        nib_val = (nib == '0) ? cur.value[7:4] : cur.value[3:0];
        nib_wt  = (nib == VALUE_LAST_NIB) ? cur.wt : WAIT_NONE;
        is_last = (nib == VALUE_LAST_NIB) && (phase == LAST_PHASE);
      end
      JOB_INIT: begin
        nib_val = init_entry.nib;
        nib_wt  = init_entry.wt;
        is_last = (nib == INIT_LAST_NIB) && (phase == LAST_PHASE);
      end
      JOB_BYTE: is_last = 1'b1;
      default:  is_last = 1'b1;
    endcase

    if (cur.op == JOB_BYTE) begin
      byte_val = cur.value;
      byte_wt  = WAIT_NONE;
    end else begin
      // data, data with EN, data again; wait only after the third beat
      byte_val = {nib_val, 4'h0} | (cur.bl ? BIT_BL : 8'h00) | (cur.rs ? BIT_RS : 8'h00);
      if (phase == 2'd1) byte_val = byte_val | BIT_EN;
      byte_wt = (phase == LAST_PHASE) ? nib_wt : WAIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      expander_byte <= byte_val;
      wait_code     <= byte_wt;
      last          <= is_last;
    end
    if (load) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      phase     <= '0;
      nib       <= '0;
    end else begin
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;

      if (load) begin
        cur_valid <= 1'b1;
        phase     <= '0;
        nib       <= '0;
      end else if (emit && is_last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        if (phase == LAST_PHASE) begin
          phase <= '0;
          nib   <= nib + 1'b1;
        end else begin
          phase <= phase + 1'b1;
        end
      end
    end
  end

  `CLNBS_ASSERT_NOW(a_phase_range, clk, rst, cur_valid, phase <= LAST_PHASE, "phase out of range")
  `CLNBS_ASSERT_NOW(a_value_nibs, clk, rst, cur_valid && (cur.op == JOB_VALUE), nib <= VALUE_LAST_NIB, "value job ran past low nibble")
  `CLNBS_ASSERT_NOW(a_init_nibs, clk, rst, cur_valid && (cur.op == JOB_INIT), nib <= INIT_LAST_NIB, "init job ran past its end")
  `CLNBS_ASSERT_NEXT(a_job_done, clk, rst, emit && is_last && !q_valid, !cur_valid, "job kept after final beat")

endmodule

@@ rtl/core/char_lcd_nibble_byte_sequencer_unit.sv @@
// A request passes the job queue and the back end's job register to the result register.
// Throughput: one port byte per cycle while pop frees the result register; a character,
//   cursor move or clear gives 6 bytes, backlight 1, init 42 (back-end nibble sequencer).
// Requests are taken every cycle until the job queue (QUEUE_DEPTH entries) fills.
// Reset (rst, synchronous): cursor at 0,0, backlight on, queue and result register empty.
module char_lcd_nibble_byte_sequencer_unit #(
  parameter int COLUMNS     = clnbs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS        = clnbs_pkg::ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = clnbs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // request side: beat taken on push && !full
  input  logic       push,
  output logic       full,
  input  logic [2:0] kind,
  input  logic [7:0] char_code,
  input  logic [7:0] target_col,
  input  logic [7:0] target_row,
  input  logic       light_on,
  // result side: beat taken on pop && !empty
  output logic       empty,
  input  logic       pop,
  output logic [7:0] expander_byte,
  output logic [1:0] wait_code,
  output logic       last
);
  import clnbs_pkg::*;

  // Front end tracks cursor and backlight and turns each request into one job:
  // a display byte (two nibbles), a raw port byte, or the init script.
  // Unknown kinds are taken and dropped.
  job_t wr_job, rd_job;
  logic q_wr, q_rd, q_full, q_valid;

  assign full = q_full;

  clnbs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .kind       (kind),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .light_on   (light_on),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_data     (wr_job)
  );

  // Short job queue: decouples request intake from byte emission.
  clnbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wr_data   (wr_job),
    .rd        (q_rd),
    .rd_data   (rd_job),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // Back end walks each job nibble by nibble, three port bytes per nibble (a raw byte job
  // gives one), into a result register; the next job loads on the final beat of the
  // current one so jobs run without a gap.
  clnbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (rd_job),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .expander_byte (expander_byte),
    .wait_code     (wait_code),
    .last          (last)
  );

endmodule
